[rtl/spq_pkg.sv]
// shared constants and types for the sorted priority queue
package spq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int PRIO_WIDTH = 16;
    localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [PRIO_WIDTH-1:0]        prio_t;
    typedef logic [CNT_WIDTH-1:0]         cnt_t;

    typedef struct packed {
        logic  insert;
        logic  remove;
        data_t data;
        prio_t prio;
    } spq_ctrl_t;

endpackage

[rtl/spq_cell.sv]
// one slot of the sorted chain: compare, then hold, load new, shift in from left or right
module spq_cell (
    input  logic               clk,
    input  spq_pkg::spq_ctrl_t ctrl,
    input  spq_pkg::cnt_t      slot_idx,
    input  spq_pkg::cnt_t      count,
    input  logic               left_move,
    input  spq_pkg::data_t     left_data,
    input  spq_pkg::prio_t     left_prio,
    input  spq_pkg::data_t     right_data,
    input  spq_pkg::prio_t     right_prio,
    output spq_pkg::data_t     data,
    output spq_pkg::prio_t     prio,
    output logic               move
);
    import spq_pkg::*;

    data_t data_reg;
    data_t data_next;
    prio_t prio_reg;
    prio_t prio_next;

    // slots past the fill level or holding a larger priority sit behind the insert point
    assign move = (slot_idx >= count) || (prio_reg > ctrl.prio);

    always_comb
    begin
        data_next = data_reg;
        prio_next = prio_reg;
        if (ctrl.insert && move)
        begin
            if (!left_move)
            begin
                data_next = ctrl.data;
                prio_next = ctrl.prio;
            end
            else
            begin
                data_next = left_data;
                prio_next = left_prio;
            end
        end
        else if (ctrl.remove)
        begin
            data_next = right_data;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        prio_reg <= prio_next;
    end

    assign data = data_reg;
    assign prio = prio_reg;

endmodule

[rtl/sorted_priority_queue.sv]
// sorted priority queue: a chain of compare-and-shift slots with the head in slot zero
// the result of a request is registered and shown in the cycle after it is accepted
// throughput: one request per cycle; every slot compares and shifts in the same cycle
// a request waits only while the previous result is held by res_stall
// reset clears the entry count and the result valid; slot contents are not cleared
module sorted_priority_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  logic                  command,
    input  spq_pkg::data_t        item_data,
    input  spq_pkg::prio_t        item_priority,
    output logic                  res_valid,
    input  logic                  res_stall,
    output logic [1:0]            status,
    output spq_pkg::data_t        removed_data,
    output spq_pkg::data_t        head_data,
    output logic                  head_valid,
    output spq_pkg::cnt_t         entry_count
);
    import spq_pkg::*;

    localparam cnt_t FULL_CNT = cnt_t'(DEPTH);

    cnt_t       count_reg;
    cnt_t       count_next;
    logic       res_valid_reg;
    logic       res_valid_next;
    logic [1:0] status_reg;
    logic [1:0] status_next;
    data_t      removed_reg;
    data_t      removed_next;
    data_t      head_reg;
    data_t      head_next;

    logic      accept;
    logic      insert_ok;
    logic      remove_ok;
    spq_ctrl_t ctrl;

    data_t slot_data [DEPTH];
    prio_t slot_prio [DEPTH];
    logic  slot_move [DEPTH];

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign insert_ok = accept && (command == CMD_INSERT) && (count_reg != FULL_CNT);
    assign remove_ok = accept && (command == CMD_REMOVE) && (count_reg != '0);

    assign ctrl.insert = insert_ok;
    assign ctrl.remove = remove_ok;
    assign ctrl.data   = item_data;
    assign ctrl.prio   = item_priority;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_slot
        logic  lm;
        data_t ld;
        prio_t lp;
        data_t rd;
        prio_t rp;

        if (k == 0)
        begin : g_first
            assign lm = 1'b0;
            assign ld = '0;
            assign lp = '0;
        end
        else
        begin : g_mid
            assign lm = slot_move[k-1];
            assign ld = slot_data[k-1];
            assign lp = slot_prio[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign rd = slot_data[k];
            assign rp = slot_prio[k];
        end
        else
        begin : g_inner
            assign rd = slot_data[k+1];
            assign rp = slot_prio[k+1];
        end

        spq_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .slot_idx   (cnt_t'(k)),
            .count      (count_reg),
            .left_move  (lm),
            .left_data  (ld),
            .left_prio  (lp),
            .right_data (rd),
            .right_prio (rp),
            .data       (slot_data[k]),
            .prio       (slot_prio[k]),
            .move       (slot_move[k])
        );
    end

    always_comb
    begin
        count_next     = count_reg;
        res_valid_next = res_valid_reg;
        status_next    = status_reg;
        removed_next   = removed_reg;
        head_next      = head_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (accept)
        begin
            res_valid_next = 1'b1;
            status_next    = ST_OK;
            removed_next   = '0;
            if (insert_ok)
            begin
                count_next = count_reg + cnt_t'(1);
            end
            else if (remove_ok)
            begin
                count_next   = count_reg - cnt_t'(1);
                removed_next = slot_data[0];
            end
            else if (command == CMD_INSERT)
            begin
                status_next = ST_FULL;
            end
            else
            begin
                status_next = ST_EMPTY;
            end

            // head after this request
            if (count_next == '0)
            begin
                head_next = '0;
            end
            else if (insert_ok && slot_move[0])
            begin
                head_next = item_data;
            end
            else if (remove_ok)
            begin
                head_next = slot_data[1];
            end
            else
            begin
                head_next = slot_data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        removed_reg <= removed_next;
        head_reg    <= head_next;
    end

    assign res_valid    = res_valid_reg;
    assign status       = status_reg;
    assign removed_data = removed_reg;
    assign head_data    = head_reg;
    assign head_valid   = (count_reg != '0);
    assign entry_count  = count_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count above depth");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_FULL |-> entry_count == FULL_CNT)
        else $error("full reject with free slots");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_EMPTY |-> entry_count == '0 && removed_data == '0)
        else $error("empty remove with entries or nonzero data");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        insert_ok |=> count_reg == $past(count_reg) + cnt_t'(1))
        else $error("insert did not advance count");

endmodule

[bench/sorted_priority_queue_tb.sv]
// self-checking testbench for the sorted priority queue: random traffic on both sides, shadow queue
module sorted_priority_queue_tb;

    import spq_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int RANDOM_REQS = 400;

    typedef struct {
        logic  cmd;
        data_t data;
        prio_t prio;
        int    gap;
        bit    hold_until_empty;
    } request_t;

    typedef struct packed {
        logic [1:0] status;
        data_t      removed;
        data_t      head;
        logic       head_valid;
        cnt_t       count;
    } outcome_t;

    logic  clk           = 1'b0;
    logic  rst_n         = 1'b0;
    logic  cmd_valid     = 1'b0;
    logic  command       = CMD_INSERT;
    data_t item_data     = '0;
    prio_t item_priority = '0;
    logic  res_stall     = 1'b0;

    logic       cmd_stall;
    logic       res_valid;
    logic [1:0] status;
    data_t      removed_data;
    data_t      head_data;
    logic       head_valid;
    cnt_t       entry_count;

    // shadow copy of the sorted store, head in slot zero
    data_t shadow_data [DEPTH];
    prio_t shadow_prio [DEPTH];
    int    shadow_count = 0;

    request_t request_backlog[$];
    outcome_t predicted_outcomes[$];

    int   errors       = 0;
    int   idle_cycles  = 0;
    logic cmd_taken    = 1'b0;
    logic res_taken    = 1'b0;
    int   send_wait    = -1;
    int   stall_left   = 3;
    int   results_seen = 0;
    bit   sink_calm    = 1'b0;
    int   planned_count = 0;
    int   random_total  = 0;

    sorted_priority_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_stall     (cmd_stall),
        .command       (command),
        .item_data     (item_data),
        .item_priority (item_priority),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .status        (status),
        .removed_data  (removed_data),
        .head_data     (head_data),
        .head_valid    (head_valid),
        .entry_count   (entry_count)
    );

    always #5 clk = ~clk;

    function automatic outcome_t queue_step_prediction(input logic cmd, input data_t d,
                                                       input prio_t p);
        outcome_t o;
        int       pos;
        o = '0;
        o.status = ST_OK;
        if (cmd == CMD_INSERT)
        begin
            if (shadow_count >= DEPTH)
                o.status = ST_FULL;
            else
            begin
                // new entry goes behind every entry of equal or smaller priority
                pos = shadow_count;
                while (pos > 0 && shadow_prio[pos-1] > p)
                begin
                    shadow_data[pos] = shadow_data[pos-1];
                    shadow_prio[pos] = shadow_prio[pos-1];
                    pos--;
                end
                shadow_data[pos] = d;
                shadow_prio[pos] = p;
                shadow_count++;
            end
        end
        else
        begin
            if (shadow_count == 0)
                o.status = ST_EMPTY;
            else
            begin
                o.removed = shadow_data[0];
                for (pos = 0; pos + 1 < shadow_count; pos++)
                begin
                    shadow_data[pos] = shadow_data[pos+1];
                    shadow_prio[pos] = shadow_prio[pos+1];
                end
                shadow_count--;
            end
        end
        o.head_valid = (shadow_count > 0);
        o.head       = (shadow_count > 0) ? shadow_data[0] : '0;
        o.count      = cnt_t'(shadow_count);
        return o;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // request and result handshakes, prediction and comparison
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        if (!rst_n)
        begin
            cmd_taken   <= 1'b0;
            res_taken   <= 1'b0;
            idle_cycles <= 0;
        end
        else
        begin
            cmd_taken <= cmd_valid && !cmd_stall;
            res_taken <= res_valid && !res_stall;
            if (res_valid && !res_stall)
            begin
                if (predicted_outcomes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual status %h count %0d",
                             $time, status, entry_count);
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    check_field("status", 32'(want.status), 32'(status));
                    check_field("removed_data", want.removed, removed_data);
                    check_field("head_data", want.head, head_data);
                    check_field("head_valid", 32'(want.head_valid), 32'(head_valid));
                    check_field("entry_count", 32'(want.count), 32'(entry_count));
                end
            end
            if (cmd_valid && !cmd_stall)
                predicted_outcomes.push_back(
                    queue_step_prediction(command, item_data, item_priority));
            if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // request driver: holds a request until taken, then waits its gap before the next
    always @(negedge clk)
    begin : request_driver
        request_t req;
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || cmd_taken)
        begin
            if (request_backlog.size() == 0)
                cmd_valid <= 1'b0;
            else if (request_backlog[0].hold_until_empty)
            begin
                cmd_valid <= 1'b0;
                if (predicted_outcomes.size() == 0)
                    void'(request_backlog.pop_front());
            end
            else
            begin
                if (send_wait < 0)
                    send_wait = request_backlog[0].gap;
                if (send_wait > 0)
                begin
                    send_wait--;
                    cmd_valid <= 1'b0;
                end
                else
                begin
                    req = request_backlog.pop_front();
                    send_wait = -1;
                    command       <= req.cmd;
                    item_data     <= req.data;
                    item_priority <= req.prio;
                    cmd_valid     <= 1'b1;
                end
            end
        end
    end

    // result side back-pressure, with calm stretches now and then
    always @(negedge clk)
    begin : result_sink
        if (rst_n)
        begin
            if (res_taken)
            begin
                results_seen++;
                if (results_seen % 40 == 0)
                    sink_calm = ($urandom_range(0, 2) == 0);
                stall_left = sink_calm ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0)
            begin
                res_stall <= 1'b1;
                stall_left--;
            end
            else
                res_stall <= 1'b0;
        end
    end

    initial
    begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

    task automatic queue_request(input logic cmd, input data_t d, input prio_t p,
                                 input int gap, input bit hold = 1'b0);
        request_t req;
        req.cmd              = cmd;
        req.data             = d;
        req.prio             = p;
        req.gap              = gap;
        req.hold_until_empty = hold;
        request_backlog.push_back(req);
        if (!hold)
        begin
            if (cmd == CMD_INSERT && planned_count < DEPTH)
                planned_count++;
            else if (cmd == CMD_REMOVE && planned_count > 0)
                planned_count--;
        end
    endtask

    task automatic random_request(input logic cmd, input bit burst, input prio_t span);
        queue_request(cmd, data_t'($urandom), prio_t'($urandom_range(0, span)),
                      burst ? 0 : $urandom_range(0, 8));
        random_total++;
    endtask

    initial
    begin : stimulus
        bit    burst;
        bit    mid_hold;
        prio_t span;
        logic  cmd;

        // directed: empty remove, extreme values, equal priorities, single entry
        queue_request(CMD_REMOVE, 32'h1234_5678, 16'h0001, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'h7fff_ffff, 16'hffff, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'h8000_0000, 16'h0000, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'h0000_0000, 16'h0000, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'hffff_ffff, 16'h8000, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'h1234_5678, 16'hffff, $urandom_range(0, 8));
        repeat (6)
            queue_request(CMD_REMOVE, 32'hffff_ffff, 16'hffff, $urandom_range(0, 8));
        queue_request(CMD_INSERT, 32'h0000_0001, 16'h0005, 0);
        queue_request(CMD_REMOVE, 32'h0000_0000, 16'h0000, 0);
        queue_request(CMD_REMOVE, 32'h0000_0000, 16'h0000, 0);
        queue_request(CMD_INSERT, '0, '0, 0, 1'b1);

        // random phases: fill to full and beyond, drain to empty and beyond, mixed
        mid_hold = 1'b0;
        while (random_total < RANDOM_REQS)
        begin
            if (!mid_hold && random_total >= RANDOM_REQS / 2)
            begin
                queue_request(CMD_INSERT, '0, '0, 0, 1'b1);
                mid_hold = 1'b1;
            end
            burst = ($urandom_range(0, 3) == 0);
            span  = $urandom_range(0, 1) ? 16'd3 : 16'hffff;
            case ($urandom_range(0, 2))
                0:
                begin
                    while (planned_count < DEPTH)
                    begin
                        cmd = ($urandom_range(0, 5) == 0) ? CMD_REMOVE : CMD_INSERT;
                        random_request(cmd, burst, span);
                    end
                    repeat ($urandom_range(1, 3))
                        random_request(CMD_INSERT, burst, span);
                end
                1:
                begin
                    while (planned_count > 0)
                    begin
                        cmd = ($urandom_range(0, 5) == 0) ? CMD_INSERT : CMD_REMOVE;
                        random_request(cmd, burst, span);
                    end
                    repeat ($urandom_range(1, 2))
                        random_request(CMD_REMOVE, burst, span);
                end
                default:
                begin
                    repeat ($urandom_range(20, 40))
                    begin
                        cmd = $urandom_range(0, 1) ? CMD_REMOVE : CMD_INSERT;
                        random_request(cmd, burst, span);
                    end
                end
            endcase
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (request_backlog.size() != 0 || cmd_valid || predicted_outcomes.size() != 0);
        repeat (10) @(posedge clk);

        if (errors == 0)
            $display("sorted_priority_queue_tb: PASS");
        else
            $display("sorted_priority_queue_tb: FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
